FILE: rtl/rvde_pkg.sv
`default_nettype none

package rvde_pkg;

   // Data memory size in bytes (power of two)
   localparam int MEM_BYTES_DEFAULT = 4096;

   // Major opcodes
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_ADD_UPPER_PC = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_MISC_MEM = 7'h0F;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   // Exact system words
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
   localparam logic [31:0] UPPER_MASK  = 32'hFFFF_F000;

   // Load size codes (funct3)
   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   // Outcome of executing one instruction
   typedef struct packed {
      logic [31:0] npc;
      logic        wr;
      logic [31:0] val;
      logic        load;
      logic        store;
      logic [2:0]  nbytes;
      logic [31:0] addr;
      logic [31:0] sval;
      logic        unk;
      logic        halt;
   } exec_type;

endpackage

`default_nettype wire

FILE: rtl/rv32i_decode_execute_top.sv
// Throughput: one instruction per cycle outside loads and stores while the output is free:
// the register file is read at the input transfer, and execute and write-back share a cycle
// in the execute state. Loads and stores step through a memory state, one data memory
// byte per cycle, and loads then through a load-done state, from which they commit.
// Reset: synchronous; clears registers to zero, the program counter to 0 and halt.
// Data memory contents are undefined until written.
`default_nettype none

module rv32i_decode_execute_top #(
   parameter int MEM_BYTES = rvde_pkg::MEM_BYTES_DEFAULT,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_next_pc,
   output logic             rsp_reg_written,
   output logic      [4:0]  rsp_dest_index,
   output logic      [31:0] rsp_dest_value,
   output logic             rsp_store_done,
   output logic      [31:0] rsp_access_address,
   output logic      [31:0] rsp_store_value,
   output logic             rsp_is_halted,
   output logic             rsp_unknown_instr
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MEM, S_LDONE} state_type;

   state_type          state_ff, state_in;
   logic [31:0]        instr_ff, pc_ff, lbuf_ff, lbuf_in, lword;
   logic               halted_ff;
   logic [1:0]         cnt_ff, cnt_in, last;
   logic [31:0]        a, b, val, ld_val;
   rvde_pkg::exec_type ex;
   logic               accept, out_free, mem_op, commit, res_wr;
   logic [7:0]         dm_q;
   logic [AW-1:0]      dm_addr;

   logic        rsp_valid_ff, rsp_wr_ff, rsp_st_ff, rsp_halt_ff, rsp_unk_ff;
   logic [4:0]  rsp_idx_ff;
   logic [31:0] rsp_npc_ff, rsp_val_ff, rsp_addr_ff, rsp_sval_ff;

   rvde_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_instruction_word[19:15]),
      .rd_addr_b (req_instruction_word[24:20]),
      .rd_data_a (a),
      .rd_data_b (b),
      .wr_en     (commit && res_wr),
      .wr_addr   (instr_ff[11:7]),
      .wr_data   (val)
   );

   rvde_exec u_exec (
      .instr (instr_ff),
      .pc    (pc_ff),
      .a     (a),
      .b     (b),
      .ex    (ex)
   );

   assign dm_addr = ex.addr[AW-1:0] + AW'(cnt_ff);

   rvde_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
      .clock   (clock),
      .wr_en   (state_ff == S_MEM && ex.store),
      .wr_addr (dm_addr),
      .wr_data (ex.sval[8*cnt_ff +: 8]),
      .rd_en   (state_ff == S_MEM && ex.load),
      .rd_addr (dm_addr),
      .rd_data (dm_q)
   );

   // Handshake and commit control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mem_op    = !halted_ff && (ex.load || ex.store);
   assign last      = 2'(ex.nbytes - 3'd1);
   assign commit    = out_free &&
                      ((state_ff == S_EXEC && !mem_op) || state_ff == S_LDONE ||
                       (state_ff == S_MEM && ex.store && cnt_ff == last));
   assign req_stall = !(state_ff == S_IDLE || commit);
   assign accept    = req_valid && !req_stall;
   assign res_wr    = !halted_ff && ex.wr && instr_ff[11:7] != 5'd0;

   // Gather load bytes; the last byte comes straight from the memory output
   always_comb begin
      lbuf_in = lbuf_ff;
      if (state_ff == S_MEM && cnt_ff != 2'd0) begin
         lbuf_in[8*(cnt_ff - 2'd1) +: 8] = dm_q;
      end
      lword = lbuf_ff;
      lword[8*last +: 8] = dm_q;
      case (instr_ff[14:12])
         rvde_pkg::F3_LB:  ld_val = {{24{lword[7]}}, lword[7:0]};
         rvde_pkg::F3_LH:  ld_val = {{16{lword[15]}}, lword[15:0]};
         rvde_pkg::F3_LBU: ld_val = {24'd0, lword[7:0]};
         rvde_pkg::F3_LHU: ld_val = {16'd0, lword[15:0]};
         default:          ld_val = lword;
      endcase
      val = (state_ff == S_LDONE) ? ld_val : ex.val;
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (mem_op) begin
               state_in = S_MEM;
               cnt_in   = 2'd0;
            end else if (commit) begin
               state_in = accept ? S_EXEC : S_IDLE;
            end
         end
         S_MEM: begin
            if (ex.load) begin
               if (cnt_ff == last) begin
                  state_in = S_LDONE;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
               end
            end else if (commit) begin
               state_in = accept ? S_EXEC : S_IDLE;
            end else if (cnt_ff != last) begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_LDONE: begin
            if (commit) state_in = accept ? S_EXEC : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 2'd0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end else if (commit) begin
            pc_ff <= halted_ff ? pc_ff : ex.npc;
         end
         if (commit) begin
            halted_ff    <= halted_ff | ex.halt;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lbuf_ff <= lbuf_in;
      if (accept) begin
         instr_ff <= req_instruction_word;
      end
      if (commit) begin
         rsp_npc_ff  <= halted_ff ? pc_ff : ex.npc;
         rsp_wr_ff   <= res_wr;
         rsp_idx_ff  <= res_wr ? instr_ff[11:7] : 5'd0;
         rsp_val_ff  <= res_wr ? val : '0;
         rsp_st_ff   <= !halted_ff && ex.store;
         rsp_addr_ff <= halted_ff ? '0 : ex.addr;
         rsp_sval_ff <= halted_ff ? '0 : ex.sval;
         rsp_halt_ff <= halted_ff | ex.halt;
         rsp_unk_ff  <= !halted_ff && ex.unk;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = rsp_npc_ff;
   assign rsp_reg_written    = rsp_wr_ff;
   assign rsp_dest_index     = rsp_idx_ff;
   assign rsp_dest_value     = rsp_val_ff;
   assign rsp_store_done     = rsp_st_ff;
   assign rsp_access_address = rsp_addr_ff;
   assign rsp_store_value    = rsp_sval_ff;
   assign rsp_is_halted      = rsp_halt_ff;
   assign rsp_unknown_instr  = rsp_unk_ff;

endmodule

`default_nettype wire

FILE: rtl/rvde_regfile.sv
`default_nettype none

module rvde_regfile (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire logic [4:0]  rd_addr_a,
   input  wire logic [4:0]  rd_addr_b,
   output logic      [31:0] rd_data_a,
   output logic      [31:0] rd_data_b,
   input  wire logic        wr_en,
   input  wire logic [4:0]  wr_addr,
   input  wire logic [31:0] wr_data
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] a_ff, b_ff;
   logic        a_valid_ff, b_valid_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Track written entries; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered reads, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (rd_en) begin
         a_valid_ff <= valid_ff[rd_addr_a] | (wr_en && wr_addr == rd_addr_a);
         b_valid_ff <= valid_ff[rd_addr_b] | (wr_en && wr_addr == rd_addr_b);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = a_valid_ff ? a_ff : '0;
   assign rd_data_b = b_valid_ff ? b_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/rvde_dmem.sv
`default_nettype none

module rvde_dmem #(
   parameter int MEM_BYTES = rvde_pkg::MEM_BYTES_DEFAULT,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] rd_data_ff;

   // One byte written and one byte read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rvde_exec.sv
`default_nettype none

module rvde_exec (
   input  wire logic [31:0]       instr,
   input  wire logic [31:0]       pc,
   input  wire logic [31:0]       a,
   input  wire logic [31:0]       b,
   output rvde_pkg::exec_type     ex
);

   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4;
   logic        lt_s, lt_u, taken;

   function automatic logic [31:0] alu(input logic [2:0] f, input logic alt,
                                       input logic [31:0] x, input logic [31:0] y);
      logic [31:0] r;
      case (f)
         3'd0:    r = alt ? x - y : x + y;
         3'd1:    r = x << y[4:0];
         3'd2:    r = {31'd0, $signed(x) < $signed(y)};
         3'd3:    r = {31'd0, x < y};
         3'd4:    r = x ^ y;
         3'd5:    r = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
         3'd6:    r = x | y;
         default: r = x & y;
      endcase
      return r;
   endfunction

   assign opc   = instr[6:0];
   assign f3    = instr[14:12];
   assign f7    = instr[31:25];
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign pc4   = pc + 32'd4;
   assign lt_s  = $signed(a) < $signed(b);
   assign lt_u  = a < b;

   // Decode and execute
   always_comb begin
      ex        = '0;
      ex.npc    = pc4;
      taken     = 1'b0;
      case (opc)
         rvde_pkg::OP_LUI: begin
            ex.wr  = 1'b1;
            ex.val = instr & rvde_pkg::UPPER_MASK;
         end
         rvde_pkg::OP_ADD_UPPER_PC: begin
            ex.wr  = 1'b1;
            ex.val = pc + (instr & rvde_pkg::UPPER_MASK);
         end
         rvde_pkg::OP_JAL: begin
            ex.wr  = 1'b1;
            ex.val = pc4;
            ex.npc = pc + imm_j;
         end
         rvde_pkg::OP_JALR: begin
            if (f3 != 3'd0) begin
               ex.unk = 1'b1;
            end else begin
               ex.wr  = 1'b1;
               ex.val = pc4;
               ex.npc = (a + imm_i) & ~32'd1;
            end
         end
         rvde_pkg::OP_BRANCH: begin
            case (f3)
               3'd0:    taken = a == b;
               3'd1:    taken = a != b;
               3'd4:    taken = lt_s;
               3'd5:    taken = !lt_s;
               3'd6:    taken = lt_u;
               3'd7:    taken = !lt_u;
               default: ex.unk = 1'b1;
            endcase
            if (taken) begin
               ex.npc = pc + imm_b;
            end
         end
         rvde_pkg::OP_LOAD: begin
            case (f3)
               rvde_pkg::F3_LB, rvde_pkg::F3_LBU: ex.nbytes = 3'd1;
               rvde_pkg::F3_LH, rvde_pkg::F3_LHU: ex.nbytes = 3'd2;
               rvde_pkg::F3_LW:                   ex.nbytes = 3'd4;
               default:                           ex.unk    = 1'b1;
            endcase
            if (!ex.unk) begin
               ex.addr = a + imm_i;
               ex.load = 1'b1;
               ex.wr   = 1'b1;
            end
         end
         rvde_pkg::OP_STORE: begin
            case (f3)
               3'd0: begin
                  ex.nbytes = 3'd1;
                  ex.sval   = {24'd0, b[7:0]};
               end
               3'd1: begin
                  ex.nbytes = 3'd2;
                  ex.sval   = {16'd0, b[15:0]};
               end
               3'd2: begin
                  ex.nbytes = 3'd4;
                  ex.sval   = b;
               end
               default: ex.unk = 1'b1;
            endcase
            if (!ex.unk) begin
               ex.addr  = a + imm_s;
               ex.store = 1'b1;
            end
         end
         rvde_pkg::OP_IMM: begin
            if ((f3 == 3'd1 && f7 != 7'h00) ||
                (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20)) begin
               ex.unk = 1'b1;
            end else begin
               ex.wr  = 1'b1;
               ex.val = alu(f3, f3 == 3'd5 && f7 == 7'h20, a, imm_i);
            end
         end
         rvde_pkg::OP_REG: begin
            if (!(f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))) begin
               ex.unk = 1'b1;
            end else begin
               ex.wr  = 1'b1;
               ex.val = alu(f3, f7 == 7'h20, a, b);
            end
         end
         rvde_pkg::OP_MISC_MEM: begin
         end
         rvde_pkg::OP_SYSTEM: begin
            if (instr == rvde_pkg::WORD_EBREAK) begin
               ex.halt = 1'b1;
            end else if (instr != rvde_pkg::WORD_ECALL) begin
               ex.unk = 1'b1;
            end
         end
         default: ex.unk = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_SIZE    = rvde_pkg::MEM_BYTES_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   // ALU, branch, store and bad load funct3 codes, funct7 values and an undefined opcode
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;
   localparam logic [2:0] F3_SB   = 3'd0;
   localparam logic [2:0] F3_SH   = 3'd1;
   localparam logic [2:0] F3_SW   = 3'd2;
   localparam logic [2:0] F3_BAD_LOAD = 3'd3;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] OP_UNDEFINED = 7'h7F;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        store_done;
      logic [31:0] access_address;
      logic [31:0] store_value;
      logic        is_halted;
      logic        unknown_instr;
   } retire_type;

   // Architectural shadow of the core plus the queue of pending retirements
   class core_scoreboard;
      logic [31:0] regs[32];
      logic [31:0] pc;
      bit          halted;
      logic [7:0]  mem[MEM_SIZE];
      bit          written[MEM_SIZE];
      int          written_list[$];
      retire_type  retire_q[$];
      int          errors, n_checked, n_loads, n_stores, n_unknown, n_taken;

      function void clear();
         foreach (regs[i]) regs[i] = '0;
         foreach (written[i]) written[i] = 0;
         written_list.delete();
         pc     = '0;
         halted = 0;
      endfunction

      function void set_start(logic [31:0] v);
         pc = v;
      endfunction

      function logic [31:0] read_mem(logic [31:0] addr, int n);
         logic [31:0] v, a;
         v = '0;
         for (int k = 0; k < n; k++) begin
            a = addr + k;
            v[8*k +: 8] = mem[a % MEM_SIZE];
         end
         return v;
      endfunction

      function void write_mem(logic [31:0] addr, logic [31:0] v, int n);
         logic [31:0] a;
         int idx;
         for (int k = 0; k < n; k++) begin
            a = addr + k;
            idx = a % MEM_SIZE;
            mem[idx] = v[8*k +: 8];
            if (!written[idx]) begin
               written[idx] = 1;
               written_list.push_back(idx);
            end
         end
      endfunction

      function logic [31:0] alu(logic [2:0] f3, bit alt, logic [31:0] a, logic [31:0] b);
         case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
         endcase
      endfunction

      // Execute one accepted instruction and queue its retirement record
      function void note_input(logic [31:0] w);
         retire_type  r;
         logic [6:0]  op, f7;
         logic [2:0]  f3;
         logic [4:0]  rd;
         logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, npc, val, addr, sval, m;
         bit          wr, st, unk, taken;
         int          n;
         op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
         a = regs[w[19:15]]; b = regs[w[24:20]];
         imm_i = {{20{w[31]}}, w[31:20]};
         imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
         imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         r = '0;
         if (halted) begin
            r.next_pc   = pc;
            r.is_halted = 1;
            retire_q.push_back(r);
            return;
         end
         npc = pc + 4; val = '0; addr = '0; sval = '0; m = '0;
         wr = 0; st = 0; unk = 0; taken = 0; n = 0;
         case (op)
            rvde_pkg::OP_LUI: begin wr = 1; val = w & rvde_pkg::UPPER_MASK; end
            rvde_pkg::OP_ADD_UPPER_PC: begin
               wr = 1; val = pc + (w & rvde_pkg::UPPER_MASK);
            end
            rvde_pkg::OP_JAL: begin wr = 1; val = pc + 4; npc = pc + imm_j; end
            rvde_pkg::OP_JALR: begin
               if (f3 != F3_ADD) unk = 1;
               else begin
                  wr = 1; val = pc + 4; npc = (a + imm_i) & ~32'd1;
               end
            end
            rvde_pkg::OP_BRANCH: begin
               case (f3)
                  F3_BEQ:  taken = (a == b);
                  F3_BNE:  taken = (a != b);
                  F3_BLT:  taken = ($signed(a) < $signed(b));
                  F3_BGE:  taken = !($signed(a) < $signed(b));
                  F3_BLTU: taken = (a < b);
                  F3_BGEU: taken = (a >= b);
                  default: unk = 1;
               endcase
               if (taken) begin
                  npc = pc + imm_b;
                  n_taken++;
               end
            end
            rvde_pkg::OP_LOAD: begin
               addr = a + imm_i;
               case (f3)
                  rvde_pkg::F3_LB: begin
                     m = read_mem(addr, 1);
                     val = {{24{m[7]}}, m[7:0]};
                  end
                  rvde_pkg::F3_LH: begin
                     m = read_mem(addr, 2);
                     val = {{16{m[15]}}, m[15:0]};
                  end
                  rvde_pkg::F3_LW:  val = read_mem(addr, 4);
                  rvde_pkg::F3_LBU: val = read_mem(addr, 1);
                  rvde_pkg::F3_LHU: val = read_mem(addr, 2);
                  default: unk = 1;
               endcase
               if (unk) addr = '0;
               else begin
                  wr = 1;
                  n_loads++;
               end
            end
            rvde_pkg::OP_STORE: begin
               addr = a + imm_s;
               case (f3)
                  F3_SB:   begin sval = b & 32'hFF;   n = 1; end
                  F3_SH:   begin sval = b & 32'hFFFF; n = 2; end
                  F3_SW:   begin sval = b;            n = 4; end
                  default: begin unk = 1; addr = '0; end
               endcase
               if (!unk) begin
                  st = 1;
                  write_mem(addr, sval, n);
                  n_stores++;
               end
            end
            rvde_pkg::OP_IMM: begin
               if (f3 == F3_SLL && f7 != F7_BASE) unk = 1;
               else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) unk = 1;
               else begin
                  wr = 1;
                  val = alu(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
               end
            end
            rvde_pkg::OP_REG: begin
               if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))))
                  unk = 1;
               else begin
                  wr = 1;
                  val = alu(f3, f7 == F7_ALT, a, b);
               end
            end
            rvde_pkg::OP_MISC_MEM: ;
            rvde_pkg::OP_SYSTEM: begin
               if (w == rvde_pkg::WORD_EBREAK) halted = 1;
               else if (w != rvde_pkg::WORD_ECALL) unk = 1;
            end
            default: unk = 1;
         endcase
         if (wr && rd != 0) begin
            regs[rd] = val;
            r.reg_written = 1;
            r.dest_index  = rd;
            r.dest_value  = val;
         end
         if (unk) n_unknown++;
         pc = npc;
         r.next_pc        = npc;
         r.store_done     = st;
         r.access_address = addr;
         r.store_value    = sval;
         r.is_halted      = halted;
         r.unknown_instr  = unk;
         retire_q.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %h, expected %h", n_checked, name, got, want));
      endtask

      // Compare one retirement against the oldest pending prediction
      task check_result(retire_type got);
         retire_type want;
         if (retire_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing pending", n_checked));
            n_checked++;
            return;
         end
         want = retire_q.pop_front();
         check_field("next_pc", got.next_pc, want.next_pc);
         check_field("reg_written", got.reg_written, want.reg_written);
         check_field("dest_index", got.dest_index, want.dest_index);
         check_field("dest_value", got.dest_value, want.dest_value);
         check_field("store_done", got.store_done, want.store_done);
         check_field("access_address", got.access_address, want.access_address);
         check_field("store_value", got.store_value, want.store_value);
         check_field("is_halted", got.is_halted, want.is_halted);
         check_field("unknown_instr", got.unknown_instr, want.unknown_instr);
         n_checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_reg_written;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic        rsp_store_done;
   logic [31:0] rsp_access_address;
   logic [31:0] rsp_store_value;
   logic        rsp_is_halted;
   logic        rsp_unknown_instr;

   core_scoreboard sb;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   rv32i_decode_execute_top DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_instruction_word(req_instruction_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_pc(rsp_next_pc), .rsp_reg_written(rsp_reg_written),
      .rsp_dest_index(rsp_dest_index), .rsp_dest_value(rsp_dest_value),
      .rsp_store_done(rsp_store_done), .rsp_access_address(rsp_access_address),
      .rsp_store_value(rsp_store_value), .rsp_is_halted(rsp_is_halted),
      .rsp_unknown_instr(rsp_unknown_instr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Observe transfers on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_input(req_instruction_word);
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_next_pc, rsp_reg_written, rsp_dest_index, rsp_dest_value,
                              rsp_store_done, rsp_access_address, rsp_store_value,
                              rsp_is_halted, rsp_unknown_instr});
      end
   end

   // Abort when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rvde_pkg::OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvde_pkg::OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvde_pkg::OP_JAL};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, rvde_pkg::OP_REG};
   endfunction

   // Point a load at bytes already stored; demote it to a bad funct3 if none fit; EBREAK becomes ECALL
   function automatic logic [31:0] retarget_load(logic [31:0] w);
      int n, t;
      bit ok;
      logic [31:0] base;
      if (w == rvde_pkg::WORD_EBREAK) return rvde_pkg::WORD_ECALL;
      if (w[6:0] != rvde_pkg::OP_LOAD) return w;
      case (w[14:12])
         rvde_pkg::F3_LB, rvde_pkg::F3_LBU: n = 1;
         rvde_pkg::F3_LH, rvde_pkg::F3_LHU: n = 2;
         rvde_pkg::F3_LW:                   n = 4;
         default:                           return w;
      endcase
      base = sb.regs[w[19:15]];
      for (int tries = 0; tries < 16 && sb.written_list.size() > 0; tries++) begin
         t = sb.written_list[$urandom_range(sb.written_list.size() - 1)];
         ok = 1;
         for (int k = 0; k < n; k++)
            if (!sb.written[(t + k) % MEM_SIZE]) ok = 0;
         if (ok) begin
            w[31:20] = 12'(t) - base[11:0];
            return w;
         end
      end
      w[14:12] = F3_BAD_LOAD;
      return w;
   endfunction

   function automatic logic [31:0] random_word();
      int          pick;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [31:0] raw;
      logic [6:0]  f7;
      pick = $urandom_range(99);
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom);
      f3 = 3'($urandom); imm = 12'($urandom); raw = $urandom;
      f7 = ($urandom_range(3) == 0) ? F7_ALT :
           (($urandom_range(9) == 0) ? 7'($urandom) : F7_BASE);
      if (pick < 8) return raw;
      if (pick < 20) return enc_r(f7, rs2, rs1, f3, rd);
      if (pick < 34) begin
         if (f3 == F3_SLL || f3 == F3_SR) imm[11:5] = f7;
         return enc_i(imm, rs1, f3, rd, rvde_pkg::OP_IMM);
      end
      if (pick < 40)
         return {raw[31:12], rd,
                 $urandom_range(1) ? rvde_pkg::OP_LUI : rvde_pkg::OP_ADD_UPPER_PC};
      if (pick < 44) return enc_j(21'(raw), rd);
      if (pick < 47)
         return enc_i(imm, rs1, ($urandom_range(5) == 0) ? f3 : F3_ADD, rd,
                      rvde_pkg::OP_JALR);
      if (pick < 57) return enc_b(13'(raw), rs2, rs1, f3);
      if (pick < 73)
         return enc_s(imm, rs2, rs1, ($urandom_range(9) == 0) ? f3 : 3'($urandom_range(2)));
      if (pick < 90) begin
         case ($urandom_range(5))
            0: f3 = rvde_pkg::F3_LB;
            1: f3 = rvde_pkg::F3_LH;
            2: f3 = rvde_pkg::F3_LW;
            3: f3 = rvde_pkg::F3_LBU;
            4: f3 = rvde_pkg::F3_LHU;
            default: ;
         endcase
         return enc_i(imm, rs1, f3, rd, rvde_pkg::OP_LOAD);
      end
      if (pick < 95) return {raw[31:7], rvde_pkg::OP_MISC_MEM};
      return $urandom_range(1) ? rvde_pkg::WORD_ECALL : {raw[31:7], rvde_pkg::OP_SYSTEM};
   endfunction

   // Offer one instruction, with random gaps first, and hold it until transfer
   task automatic send_word(logic [31:0] w, bit retarget);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_instruction_word <= retarget ? retarget_load(w) : w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic send_random(int count);
      repeat (count) send_word(random_word(), 1);
   endtask

   // Drop valid and wait until every prediction has retired
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.retire_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_start(logic [31:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      sb.set_start(v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [31:0] directed[$];
      sb = new();
      sb.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, x0 writes, wrapping accesses, ECALL, fence and unknown system words
      directed.push_back({20'hFFFFF, 5'd1, rvde_pkg::OP_LUI});
      directed.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, rvde_pkg::OP_IMM));
      directed.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, rvde_pkg::OP_IMM));
      directed.push_back(enc_i(12'h005, 5'd1, F3_ADD, 5'd0, rvde_pkg::OP_IMM));
      directed.push_back(enc_s(12'h000, 5'd2, 5'd0, F3_SW));
      directed.push_back(enc_s(12'hFFE, 5'd1, 5'd0, F3_SW));
      directed.push_back(enc_s(12'h008, 5'd3, 5'd0, F3_SH));
      directed.push_back(enc_s(12'h00A, 5'd2, 5'd0, F3_SB));
      directed.push_back(enc_i(12'hFFE, 5'd0, rvde_pkg::F3_LW, 5'd4, rvde_pkg::OP_LOAD));
      directed.push_back(enc_i(12'h008, 5'd0, rvde_pkg::F3_LH, 5'd5, rvde_pkg::OP_LOAD));
      directed.push_back(enc_i(12'hFFE, 5'd0, rvde_pkg::F3_LHU, 5'd6, rvde_pkg::OP_LOAD));
      directed.push_back(enc_i(12'h00A, 5'd0, rvde_pkg::F3_LB, 5'd7, rvde_pkg::OP_LOAD));
      directed.push_back(enc_i(12'h000, 5'd0, rvde_pkg::F3_LBU, 5'd8, rvde_pkg::OP_LOAD));
      directed.push_back({20'h80000, 5'd9, rvde_pkg::OP_ADD_UPPER_PC});
      directed.push_back(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd10));
      directed.push_back(enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd11));
      directed.push_back(enc_i(12'h025, 5'd1, F3_SLL, 5'd12, rvde_pkg::OP_IMM));
      directed.push_back(enc_i(12'h404, 5'd1, F3_SR, 5'd12, rvde_pkg::OP_IMM));
      directed.push_back(enc_b(13'h0008, 5'd0, 5'd0, F3_BEQ));
      directed.push_back(enc_b(13'h1FF0, 5'd0, 5'd1, F3_BLT));
      directed.push_back(enc_j(21'h1FF800, 5'd13));
      directed.push_back(enc_i(12'h7FF, 5'd3, F3_ADD, 5'd14, rvde_pkg::OP_JALR));
      directed.push_back(rvde_pkg::WORD_ECALL);
      directed.push_back(32'h8330_000F);
      directed.push_back(32'h0100_000F);
      directed.push_back(32'h0020_0073);
      directed.push_back({25'h1ABCDEF, OP_UNDEFINED});

      // Phase one: occasional sender gaps, frequent receiver stalls
      write_start(32'hFFFF_FFFF);
      send_idle = 10; recv_idle = 63;
      foreach (directed[i]) send_word(directed[i], 0);
      send_random(380);
      drain();

      // Phase two: roles swapped
      write_start(32'h0000_0000);
      send_idle = 63; recv_idle = 10;
      send_random(400);
      drain();

      // Phase three: no idling, one long receiver hold-off to back up the input
      write_start($urandom);
      send_idle = 0; recv_idle = 0;
      hold_left = HOLD_CYCLES;
      send_random(430);
      send_word(rvde_pkg::WORD_EBREAK, 0);
      send_random(6);
      drain();

      repeat (20) @(posedge clock);
      $display("Checked %0d retirements: %0d loads, %0d stores, %0d taken branches,",
               sb.n_checked, sb.n_loads, sb.n_stores, sb.n_taken);
      $display("%0d unknown encodings, three start addresses, halt with trailing words.",
               sb.n_unknown);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

`default_nettype wire
